### design/utrd_pkg.sv
// ----------------------------------------------------------------------------
// UUID text radix decoder package
// Shared types, constants and character lookup functions.
// ----------------------------------------------------------------------------
package utrd_pkg;

	localparam int FifoDepth = 4;
	localparam int FifoPtrW  = $clog2(FifoDepth);

	localparam logic RegMode = 1'b0;
	localparam logic RegBase = 1'b1;

	localparam logic [3:0] ModeReset = 4'd8;
	localparam logic [6:0] BaseReset = 7'd16;

	typedef enum logic [3:0] {
		ModeNumeric = 4'd0,
		ModeB64     = 4'd1,
		ModeB32     = 4'd2,
		ModeB32Hex  = 4'd3,
		ModeB16     = 4'd4,
		ModeB36     = 4'd5,
		ModeB62     = 4'd6,
		ModeUuid    = 4'd7,
		ModeAuto    = 4'd8
	} utrd_mode_t;

	typedef struct packed {
		logic [5:0] sel_digit;
		logic [6:0] sel_radix;
		logic       sel_err;
		logic [3:0] hex_digit;
		logic       hex_err;
		logic       dash_skip;
		logic       dash_err;
		logic [4:0] b32_digit;
		logic       b32_err;
		logic [5:0] b36_digit;
		logic       b36_err;
		logic [5:0] b62_digit;
		logic       b62_err;
		logic       last;
		logic [3:0] mode;
		logic [5:0] count;
	} utrd_item_t;

	// Folds a lower-case letter to upper case. The lookups below return
	// {valid, digit}.
	function automatic logic [7:0] fold_upper(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h61 && c <= 8'h7a) r = c - 8'd32;
		return r;
	endfunction

	// Alphabet 0-9A-Za-z+/
	function automatic logic [6:0] std_digit(input logic [7:0] c);
		logic [6:0] r;
		r = 7'd0;
		if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 6'(c - 8'h30)};
		else if (c >= 8'h41 && c <= 8'h5a) r = {1'b1, 6'(c - 8'h41 + 8'd10)};
		else if (c >= 8'h61 && c <= 8'h7a) r = {1'b1, 6'(c - 8'h61 + 8'd36)};
		else if (c == 8'h2b) r = {1'b1, 6'd62};
		else if (c == 8'h2f) r = {1'b1, 6'd63};
		return r;
	endfunction

	// Alphabet A-Za-z0-9+/
	function automatic logic [6:0] b64_digit(input logic [7:0] c);
		logic [6:0] r;
		r = 7'd0;
		if (c >= 8'h41 && c <= 8'h5a) r = {1'b1, 6'(c - 8'h41)};
		else if (c >= 8'h61 && c <= 8'h7a) r = {1'b1, 6'(c - 8'h61 + 8'd26)};
		else if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 6'(c - 8'h30 + 8'd52)};
		else if (c == 8'h2b) r = {1'b1, 6'd62};
		else if (c == 8'h2f) r = {1'b1, 6'd63};
		return r;
	endfunction

	// Alphabet A-Z2-7, case folded
	function automatic logic [6:0] b32_lookup(input logic [7:0] c);
		logic [7:0] u;
		logic [6:0] r;
		u = fold_upper(c);
		r = 7'd0;
		if (u >= 8'h41 && u <= 8'h5a) r = {1'b1, 6'(u - 8'h41)};
		else if (u >= 8'h32 && u <= 8'h37) r = {1'b1, 6'(u - 8'h32 + 8'd26)};
		return r;
	endfunction

	// Alphabet 0-9A-Z with case folding; the caller limits the radix.
	function automatic logic [6:0] folded_digit(input logic [7:0] c);
		return std_digit(fold_upper(c));
	endfunction

endpackage

### design/utrd_front.sv
// ----------------------------------------------------------------------------
// UUID text radix decoder front end
// Holds the registers and the character count and turns each character into
// digits and error bits for every decoder.
// ----------------------------------------------------------------------------
module utrd_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [7:0]            cfg_data,
	input  logic                  in_valid,
	input  logic [7:0]            in_char,
	input  logic                  in_last,
	input  logic                  fifo_full,
	output logic                  push,
	output utrd_pkg::utrd_item_t  item
);

	logic [3:0] mode_q;
	logic [6:0] base_q;
	logic [5:0] count_q;
	logic [5:0] count_next;
	logic [6:0] sd, b64, b32, fd, sel;
	logic       is_dash_pos;

	assign cfg_ready = 1'b1;
	assign push      = in_valid && !fifo_full;
	assign count_next = (count_q == 6'd63) ? count_q : count_q + 6'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= utrd_pkg::ModeReset;
			base_q <= utrd_pkg::BaseReset;
		end else if (cfg_valid) begin
			if (cfg_index == utrd_pkg::RegMode) mode_q <= cfg_data[3:0];
			else base_q <= cfg_data[6:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 6'd0;
		end else if (push) begin
			count_q <= in_last ? 6'd0 : count_next;
		end
	end

	always_comb begin
		sd  = utrd_pkg::std_digit(in_char);
		b64 = utrd_pkg::b64_digit(in_char);
		b32 = utrd_pkg::b32_lookup(in_char);
		fd  = utrd_pkg::folded_digit(in_char);
		is_dash_pos = (count_q == 6'd8) || (count_q == 6'd13) ||
			(count_q == 6'd18) || (count_q == 6'd23);
		sel = 7'd0;
		item.sel_radix = 7'd64;
		item.sel_err   = 1'b0;
		unique case (mode_q)
			utrd_pkg::ModeNumeric: begin
				item.sel_radix = base_q;
				sel = sd;
				item.sel_err = (base_q < 7'd2) || (base_q > 7'd64) || !sd[6] ||
					({1'b0, sd[5:0]} >= base_q);
			end
			utrd_pkg::ModeB32: begin
				item.sel_radix = 7'd32;
				sel = b32;
				item.sel_err = !b32[6];
			end
			utrd_pkg::ModeB32Hex: begin
				item.sel_radix = 7'd32;
				sel = fd;
				item.sel_err = !fd[6] || (fd[5:0] >= 6'd32);
			end
			utrd_pkg::ModeB16: begin
				item.sel_radix = 7'd16;
				sel = fd;
				item.sel_err = !fd[6] || (fd[5:0] >= 6'd16);
			end
			utrd_pkg::ModeB36: begin
				item.sel_radix = 7'd36;
				sel = fd;
				item.sel_err = !fd[6] || (fd[5:0] >= 6'd36);
			end
			utrd_pkg::ModeB62: begin
				item.sel_radix = 7'd62;
				sel = sd;
				item.sel_err = !sd[6] || (sd[5:0] >= 6'd62);
			end
			utrd_pkg::ModeB64, utrd_pkg::ModeUuid, utrd_pkg::ModeAuto: begin
				sel = b64;
				item.sel_err = !b64[6];
			end
			default: begin
				item.sel_err = 1'b1;
			end
		endcase
		item.sel_digit = sel[5:0];
		item.hex_digit = fd[3:0];
		item.hex_err   = !fd[6] || (fd[5:0] >= 6'd16);
		item.dash_skip = is_dash_pos;
		item.dash_err  = is_dash_pos ? (in_char != 8'h2d) : item.hex_err;
		item.b32_digit = b32[4:0];
		item.b32_err   = !b32[6];
		item.b36_digit = fd[5:0];
		item.b36_err   = !fd[6] || (fd[5:0] >= 6'd36);
		item.b62_digit = sd[5:0];
		item.b62_err   = !sd[6] || (sd[5:0] >= 6'd62);
		item.last      = in_last;
		item.mode      = mode_q;
		item.count     = count_next;
	end

endmodule

### design/utrd_fifo.sv
// ----------------------------------------------------------------------------
// UUID text radix decoder queue
// Short register queue of classified characters between front and back.
// ----------------------------------------------------------------------------
module utrd_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  utrd_pkg::utrd_item_t  wr_item,
	input  logic                  pop,
	output utrd_pkg::utrd_item_t  rd_item,
	output logic                  empty,
	output logic                  full
);

	utrd_pkg::utrd_item_t mem_q [utrd_pkg::FifoDepth];
	logic [utrd_pkg::FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [utrd_pkg::FifoPtrW:0]   cnt_q;

	assign empty   = (cnt_q == '0);
	assign full    = (cnt_q == (utrd_pkg::FifoPtrW+1)'(utrd_pkg::FifoDepth));
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

### design/utrd_back.sv
// ----------------------------------------------------------------------------
// UUID text radix decoder back end
// Runs the six 128-bit accumulators and picks and registers the result.
// ----------------------------------------------------------------------------
module utrd_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	input  utrd_pkg::utrd_item_t  it,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [135:0]          out_data
);

	logic [127:0] sel_q, hexc_q, hexd_q, b32_q, b36_q, b62_q;
	logic [127:0] sel_n, hexc_n, hexd_n, b32_n, b36_n, b62_n;
	logic [5:0]   err_q, err_n;
	logic [127:0] res;
	logic [127:0] res_q;
	logic         out_valid_q;

	assign pop = !q_empty && (!it.last || !out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data = {2'b00, (res_q[63:61] == 3'b111) ? 2'd3 :
		(res_q[63:62] == 2'b11) ? 2'd2 : res_q[63] ? 2'd1 : 2'd0,
		res_q[79:76], res_q[63:0], res_q[127:64]};

	always_comb begin
		sel_n  = it.sel_err ? sel_q :
			128'(sel_q * 128'(it.sel_radix)) + 128'(it.sel_digit);
		hexc_n = it.hex_err ? hexc_q : (hexc_q << 4) + 128'(it.hex_digit);
		hexd_n = (it.dash_err || it.dash_skip) ? hexd_q :
			(hexd_q << 4) + 128'(it.hex_digit);
		b32_n  = it.b32_err ? b32_q : (b32_q << 5) + 128'(it.b32_digit);
		b36_n  = it.b36_err ? b36_q :
			(b36_q << 5) + (b36_q << 2) + 128'(it.b36_digit);
		b62_n  = it.b62_err ? b62_q :
			(b62_q << 6) - (b62_q << 1) + 128'(it.b62_digit);
		err_n  = err_q | {it.b62_err, it.b36_err, it.b32_err, it.dash_err,
			it.hex_err, it.sel_err};
	end

	// Result selection on the final character, from the updated state.
	always_comb begin
		res = '0;
		if (it.mode <= 4'(utrd_pkg::ModeB62)) begin
			if (!err_n[0]) res = sel_n;
		end else if (it.mode == 4'(utrd_pkg::ModeUuid) ||
			it.mode == 4'(utrd_pkg::ModeAuto)) begin
			if (it.count == 6'd32) begin
				if (!err_n[1]) res = hexc_n;
			end else if (it.count == 6'd36) begin
				if (!err_n[2]) res = hexd_n;
			end else if (it.mode == 4'(utrd_pkg::ModeAuto)) begin
				if (it.count == 6'd26) begin
					if (!err_n[3]) res = b32_n;
				end else if (it.count == 6'd25 || it.count == 6'd24) begin
					if (!err_n[4]) res = b36_n;
				end else if (it.count == 6'd22) begin
					// Base64 that fails or decodes to nil falls back to base62.
					if (!err_n[0] && (sel_n != '0)) res = sel_n;
					else if (!err_n[5]) res = b62_n;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= '0; hexc_q <= '0; hexd_q <= '0;
			b32_q <= '0; b36_q  <= '0; b62_q  <= '0;
			err_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && it.last) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (pop) begin
				if (it.last) begin
					sel_q <= '0; hexc_q <= '0; hexd_q <= '0;
					b32_q <= '0; b36_q  <= '0; b62_q  <= '0;
					err_q <= '0;
				end else begin
					sel_q <= sel_n; hexc_q <= hexc_n; hexd_q <= hexd_n;
					b32_q <= b32_n; b36_q  <= b36_n;  b62_q  <= b62_n;
					err_q <= err_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && it.last) res_q <= res;
	end

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop && it.last |=> (err_q == '0) && (sel_q == '0) && (b62_q == '0))
		else $error("state not cleared after final beat");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !(pop && it.last))
		else $error("pending result overwritten");
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		pop && it.last |=> out_valid_q)
		else $error("final beat gave no result");

endmodule

### design/uuid_text_radix_decoder.sv
// ----------------------------------------------------------------------------
// UUID text radix decoder
// Decodes a streamed identifier string into a 128-bit value with version
// nibble and variant class.
// ----------------------------------------------------------------------------
// channel  | direction | handshake           | content
// s_*      | in        | s_tvalid/s_tready   | one character, tlast on final
// m_*      | out       | m_tvalid/m_tready   | decoded value per string
// cfg_*    | in        | cfg_valid/cfg_ready | register index and data
//
// One beat is taken per cycle while the queue is not full. A beat is queued
// when accepted and popped in a later cycle, where the six accumulators take
// one multiply-add step; a final beat registers its result and m_tvalid at
// that pop, via the queue entry and then the result register. Only a final
// beat waits on a pending result; then the four-entry queue fills and
// s_tready drops. Reset clears the accumulators and loads register defaults.
module uuid_text_radix_decoder (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // char_code
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [135:0] m_tdata,   // value_hi, value_lo, version, variant
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [7:0]   cfg_data
);

	utrd_pkg::utrd_item_t wr_item, rd_item;
	logic push, pop, empty, full;

	assign s_tready = !full;

	utrd_front u_front (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(s_tvalid), .in_char(s_tdata), .in_last(s_tlast),
		.fifo_full(full), .push(push), .item(wr_item)
	);

	utrd_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(push), .wr_item(wr_item),
		.pop(pop), .rd_item(rd_item),
		.empty(empty), .full(full)
	);

	utrd_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_empty(empty), .it(rd_item), .pop(pop),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata)
	);

endmodule
